// File: hw/rtl/mlqs_pkg.sv
// Package for the multilevel queue scheduler: sizes, opcodes, levels, states.
// No dependencies.
`timescale 1ns / 1ps
package mlqs_pkg;
  localparam int TaskSlots = 64;
  localparam int SlotW = $clog2(TaskSlots);

  typedef enum logic [2:0] {
    OP_ADMIT = 3'd0, OP_SET_RUN = 3'd1, OP_END_RUN = 3'd2, OP_SET_QUEUE = 3'd3,
    OP_SET_PRIO = 3'd4, OP_SCHEDULE = 3'd5, OP_FREE = 3'd6, OP_NOP = 3'd7
  } opcode_e;

  localparam logic [1:0] LvlRr = 2'd1;
  localparam logic [1:0] LvlLcfs = 2'd2;
  localparam logic [1:0] LvlMhrrn = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD, ST_OP, ST_SCAN_RD, ST_SCAN_EVAL, ST_DIV, ST_MUL1, ST_MUL2,
    ST_CMP, ST_PICK, ST_AGE_RD, ST_AGE_WR, ST_OUT
  } state_e;
endpackage

// File: hw/rtl/multilevel_queue_scheduler_unit.sv
// Simple ops pass the read, op and output states; schedule reads and evaluates
// each slot per queue pass (up to three), adding a divide and two products for
// a runnable MHRRN slot (one divider, one 32x32 multiplier used twice), then an
// aging pass visits each slot. One request at a time; in_stall_o is high while
// a request is in progress or its result waits. Reset clears occupied/runnable
// flags and sets aging_limit to 10. Depends on mlqs_pkg.
`timescale 1ns / 1ps
module multilevel_queue_scheduler_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  opcode_i,
  input  logic [5:0]  slot_i,
  input  logic        runnable_flag_i,
  input  logic [1:0]  queue_level_i,
  input  logic [7:0]  priority_value_i,
  input  logic [31:0] now_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        chosen_valid_o,
  output logic [5:0]  chosen_slot_o,
  output logic        status_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);
  localparam int SW = mlqs_pkg::SlotW;
  localparam int N = mlqs_pkg::TaskSlots;

  mlqs_pkg::state_e state_q, state_d;

  // flag vectors and per-slot memories
  logic [N-1:0] occ_q, run_q;
  logic [1:0]  lvl_mem [N];
  logic [31:0] arr_mem [N];
  logic [31:0] rc_mem  [N];
  logic [15:0] wc_mem  [N];
  logic [7:0]  pr_mem  [N];

  logic [15:0] aging_q;
  logic [2:0]  op_q;
  logic [5:0]  slot_q;
  logic        fl_q;
  logic [1:0]  ql_q;
  logic [7:0]  pv_q;
  logic [31:0] now_q;

  // registered read port
  logic [SW-1:0] ra;
  logic [1:0]  r_lvl;
  logic [31:0] r_arr, r_rc;
  logic [15:0] r_wc;
  logic [7:0]  r_pr;

  // scan state
  logic [SW:0]   idx_q, idx_d;
  logic [1:0]    pass_q, pass_d;
  logic          found_q, found_d;
  logic [SW-1:0] best_q, best_d;
  logic [31:0]   barr_q, barr_d;
  logic [32:0]   bk_q, bk_d;
  logic [31:0]   brem_q, brem_d, brc_q, brc_d;
  // candidate MHRRN values
  logic [32:0]   ck_q, ck_d;
  logic [31:0]   crem_q, crem_d, crc_q, crc_d;
  // divider
  logic [31:0]   dq_q, dq_d, dr_q, dr_d;
  logic [5:0]    dcnt_q, dcnt_d;
  logic [63:0]   p1_q, p1_d;
  logic [63:0]   mul_p;
  logic [31:0]   mul_a, mul_b;

  logic          ov_q, ov_d, cv_q, cv_d, st_q, st_d;
  logic [5:0]    cs_q, cs_d;

  // write port
  logic          we;
  logic [SW-1:0] wa;
  logic [1:0]    w_lvl;
  logic [31:0]   w_arr, w_rc;
  logic [15:0]   w_wc;
  logic [7:0]    w_pr;

  logic          inrange, occ;
  logic [32:0]   div_sub;
  logic          cand_better, wait_inc;
  logic [15:0]   wc_new;

  assign inrange = ({{(32-6){1'b0}}, slot_q} < 32'(N));
  assign occ = inrange && occ_q[slot_q[SW-1:0]];
  assign in_stall_o = (state_q != mlqs_pkg::ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = ov_q;
  assign chosen_valid_o = cv_q;
  assign chosen_slot_o = cs_q;
  assign status_o = st_q;
  assign mul_p = 64'(mul_a) * 64'(mul_b);
  assign div_sub = {dr_q, dq_q[31]} - {1'b0, crc_q};

  // memories
  always_ff @(posedge clk_i) begin
    if (we) begin
      lvl_mem[wa] <= w_lvl;
      arr_mem[wa] <= w_arr;
      rc_mem[wa]  <= w_rc;
      wc_mem[wa]  <= w_wc;
      pr_mem[wa]  <= w_pr;
    end
    r_lvl <= lvl_mem[ra];
    r_arr <= arr_mem[ra];
    r_rc  <= rc_mem[ra];
    r_wc  <= wc_mem[ra];
    r_pr  <= pr_mem[ra];
  end

  // scan candidate comparison
  always_comb begin
    cand_better = 1'b0;
    if (pass_q == 2'd0) cand_better = !found_q || (r_arr < barr_q);
    else if (pass_q == 2'd1) cand_better = !found_q || (r_arr > barr_q);
    else cand_better = !found_q || (ck_q > bk_q) ||
                       ((ck_q == bk_q) && (p1_q > mul_p));
    wait_inc = run_q[idx_q[SW-1:0]] && (idx_q[SW-1:0] != best_q);
    wc_new = (idx_q[SW-1:0] == best_q) ? 16'd0 :
             (r_wc != 16'hFFFF) ? r_wc + 16'd1 : r_wc;
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    idx_d = idx_q; pass_d = pass_q; found_d = found_q; best_d = best_q;
    barr_d = barr_q; bk_d = bk_q; brem_d = brem_q; brc_d = brc_q;
    ck_d = ck_q; crem_d = crem_q; crc_d = crc_q;
    dq_d = dq_q; dr_d = dr_q; dcnt_d = dcnt_q; p1_d = p1_q;
    ov_d = ov_q; cv_d = cv_q; cs_d = cs_q; st_d = st_q;
    ra = slot_q[SW-1:0];
    we = 1'b0; wa = slot_q[SW-1:0];
    w_lvl = r_lvl; w_arr = r_arr; w_rc = r_rc; w_wc = r_wc; w_pr = r_pr;
    mul_a = crem_q; mul_b = brc_q;
    case (state_q)
      mlqs_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = mlqs_pkg::ST_RD;
      end
      mlqs_pkg::ST_RD: begin
        if (op_q == mlqs_pkg::OP_SCHEDULE) begin
          idx_d = '0; pass_d = 2'd0; found_d = 1'b0; best_d = '0;
          state_d = mlqs_pkg::ST_SCAN_RD;
        end else state_d = mlqs_pkg::ST_OP;
      end
      mlqs_pkg::ST_OP: begin
        cv_d = 1'b0; cs_d = '0; st_d = 1'b0;
        case (op_q)
          mlqs_pkg::OP_ADMIT: begin
            if (!inrange) st_d = 1'b1;
            else begin
              we = 1'b1; w_lvl = mlqs_pkg::LvlLcfs; w_arr = now_q; w_rc = 32'd1;
              w_wc = '0; w_pr = pv_q;
            end
          end
          mlqs_pkg::OP_NOP, mlqs_pkg::OP_SCHEDULE: ;
          default: begin
            if (!occ) st_d = 1'b1;
            else if (op_q == mlqs_pkg::OP_END_RUN) begin
              we = fl_q && (r_lvl == mlqs_pkg::LvlRr); w_arr = now_q;
            end else if (op_q == mlqs_pkg::OP_SET_QUEUE) begin
              we = 1'b1; w_wc = '0;
              w_lvl = (ql_q == 2'd0) ? mlqs_pkg::LvlRr : ql_q;
            end else if (op_q == mlqs_pkg::OP_SET_PRIO) begin
              we = 1'b1; w_pr = pv_q;
            end
          end
        endcase
        ov_d = 1'b1; state_d = mlqs_pkg::ST_OUT;
      end
      mlqs_pkg::ST_SCAN_RD: begin
        ra = idx_q[SW-1:0];
        state_d = mlqs_pkg::ST_SCAN_EVAL;
      end
      mlqs_pkg::ST_SCAN_EVAL: begin
        if (run_q[idx_q[SW-1:0]] && r_lvl == 2'(pass_q + 2'd1)) begin
          if (pass_q == 2'd2) begin
            crc_d = (r_rc == 32'd0) ? 32'd1 : r_rc;
            dq_d = now_q - r_arr; dr_d = '0; dcnt_d = '0; crem_d = {24'd0, r_pr};
            state_d = mlqs_pkg::ST_DIV;
          end else begin
            if (cand_better) begin
              found_d = 1'b1; best_d = idx_q[SW-1:0]; barr_d = r_arr;
            end
            state_d = mlqs_pkg::ST_PICK;
          end
        end else state_d = mlqs_pkg::ST_PICK;
      end
      mlqs_pkg::ST_DIV: begin
        // restoring division, one quotient bit per cycle
        if (!div_sub[32]) dr_d = div_sub[31:0];
        else dr_d = {dr_q[30:0], dq_q[31]};
        dq_d = {dq_q[30:0], !div_sub[32]};
        dcnt_d = dcnt_q + 6'd1;
        if (dcnt_q == 6'd31) state_d = mlqs_pkg::ST_MUL1;
      end
      mlqs_pkg::ST_MUL1: begin
        ck_d = {1'b0, dq_q} + {25'd0, crem_q[7:0]};
        crem_d = dr_q;
        state_d = mlqs_pkg::ST_MUL2;
      end
      mlqs_pkg::ST_MUL2: begin
        p1_d = mul_p;
        state_d = mlqs_pkg::ST_CMP;
      end
      mlqs_pkg::ST_CMP: begin
        mul_a = brem_q; mul_b = crc_q;
        if (cand_better) begin
          found_d = 1'b1; best_d = idx_q[SW-1:0];
          bk_d = ck_q; brem_d = crem_q; brc_d = crc_q;
        end
        state_d = mlqs_pkg::ST_PICK;
      end
      mlqs_pkg::ST_PICK: begin
        if (idx_q != (SW+1)'(N-1)) begin
          idx_d = idx_q + (SW+1)'(1); state_d = mlqs_pkg::ST_SCAN_RD;
        end else if (found_q) begin
          idx_d = '0; state_d = mlqs_pkg::ST_AGE_RD;
        end else if (pass_q != 2'd2) begin
          idx_d = '0; pass_d = pass_q + 2'd1; state_d = mlqs_pkg::ST_SCAN_RD;
        end else begin
          cv_d = 1'b0; cs_d = '0; st_d = 1'b0; ov_d = 1'b1;
          state_d = mlqs_pkg::ST_OUT;
        end
      end
      mlqs_pkg::ST_AGE_RD: begin
        ra = idx_q[SW-1:0];
        state_d = mlqs_pkg::ST_AGE_WR;
      end
      mlqs_pkg::ST_AGE_WR: begin
        // chosen slot: run count up, wait cleared; other runnable slots wait and age
        wa = idx_q[SW-1:0];
        if (idx_q[SW-1:0] == best_q) begin
          we = 1'b1; w_wc = '0;
          if (r_rc != 32'hFFFF_FFFF) w_rc = r_rc + 32'd1;
        end else if (wait_inc) begin
          we = 1'b1; w_wc = wc_new;
          if (wc_new > aging_q) begin
            w_wc = '0;
            if (r_lvl > mlqs_pkg::LvlRr) w_lvl = r_lvl - 2'd1;
          end
        end
        if (idx_q != (SW+1)'(N-1)) begin
          idx_d = idx_q + (SW+1)'(1); state_d = mlqs_pkg::ST_AGE_RD;
        end else begin
          cv_d = 1'b1; cs_d = 6'(best_q); st_d = 1'b0; ov_d = 1'b1;
          state_d = mlqs_pkg::ST_OUT;
        end
      end
      mlqs_pkg::ST_OUT: begin
        if (!out_stall_i) begin
          ov_d = 1'b0; state_d = mlqs_pkg::ST_IDLE;
        end
      end
      default: state_d = mlqs_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mlqs_pkg::ST_IDLE;
      occ_q <= '0; run_q <= '0; aging_q <= 16'd10; ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q <= ov_d;
      if (cfg_valid_i && cfg_ready_o) aging_q <= cfg_data_i;
      if (state_q == mlqs_pkg::ST_OP) begin
        if (op_q == mlqs_pkg::OP_ADMIT && inrange) begin
          occ_q[slot_q[SW-1:0]] <= 1'b1; run_q[slot_q[SW-1:0]] <= fl_q;
        end else if (occ && (op_q == mlqs_pkg::OP_SET_RUN ||
                             op_q == mlqs_pkg::OP_END_RUN)) begin
          run_q[slot_q[SW-1:0]] <= fl_q;
        end else if (occ && op_q == mlqs_pkg::OP_FREE) begin
          occ_q[slot_q[SW-1:0]] <= 1'b0; run_q[slot_q[SW-1:0]] <= 1'b0;
        end
      end
      if (state_q == mlqs_pkg::ST_AGE_WR && idx_q == (SW+1)'(N-1))
        run_q[best_q] <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == mlqs_pkg::ST_IDLE && in_valid_i) begin
      op_q <= opcode_i; slot_q <= slot_i; fl_q <= runnable_flag_i;
      ql_q <= queue_level_i; pv_q <= priority_value_i; now_q <= now_i;
    end
    idx_q <= idx_d; pass_q <= pass_d; found_q <= found_d; best_q <= best_d;
    barr_q <= barr_d; bk_q <= bk_d; brem_q <= brem_d; brc_q <= brc_d;
    ck_q <= ck_d; crem_q <= crem_d; crc_q <= crc_d;
    dq_q <= dq_d; dr_q <= dr_d; dcnt_q <= dcnt_d; p1_q <= p1_d;
    cv_q <= cv_d; cs_q <= cs_d; st_q <= st_d;
  end
endmodule

// File: hw/rtl/mlqs_checker.sv
// Port-level checks for the multilevel queue scheduler, bound to the top level.
// Depends on multilevel_queue_scheduler_unit ports only.
`timescale 1ns / 1ps
module mlqs_checker (
  input logic clk_i, rst_ni, in_valid_i, in_stall_o, out_valid_o, out_stall_i,
  input logic chosen_valid_o, status_o,
  input logic [5:0] chosen_slot_o
);
  a_no_slot_when_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !chosen_valid_o |-> chosen_slot_o == 6'd0) else $error("slot set");
  a_busy_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("ready while result pending");
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(chosen_valid_o && status_o)) else $error("both flags");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(chosen_slot_o))
    else $error("result dropped");
endmodule

bind multilevel_queue_scheduler_unit mlqs_checker u_chk (.*);

// File: dv/tb.sv
// Testbench for multilevel_queue_scheduler_unit: directed and random operations
// checked against an in-bench scheduler predictor. Depends on mlqs_pkg and the RTL.
`timescale 1ns / 1ps
module tb;
  typedef struct packed {
    logic       chosen_valid;
    logic [5:0] chosen_slot;
    logic       status;
  } sched_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  opcode_i = '0;
  logic [5:0]  slot_i = '0;
  logic        runnable_flag_i = 1'b0;
  logic [1:0]  queue_level_i = '0;
  logic [7:0]  priority_value_i = '0;
  logic [31:0] now_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        chosen_valid_o;
  logic [5:0]  chosen_slot_o;
  logic        status_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i = '0;

  multilevel_queue_scheduler_unit u_dut (.*);

  // Predictor state
  logic [15:0] aging_lim;
  bit          t_occ [mlqs_pkg::TaskSlots];
  bit          t_run [mlqs_pkg::TaskSlots];
  logic [1:0]  t_lvl [mlqs_pkg::TaskSlots];
  logic [31:0] t_arr [mlqs_pkg::TaskSlots];
  logic [31:0] t_runs[mlqs_pkg::TaskSlots];
  logic [15:0] t_wait[mlqs_pkg::TaskSlots];
  logic [7:0]  t_prio[mlqs_pkg::TaskSlots];

  sched_res_t  expected_q[$];
  int          errors = 0;
  int          results_seen = 0;
  int          scheds_hit = 0;
  bit          rx_idle_en = 1'b1;
  bit          tx_idle_en = 1'b1;
  bit          hold_rx = 1'b0;
  logic [31:0] tick = '0;

  initial forever #5 clk_i = ~clk_i;

  initial begin
    #100000000;
    $display("Timeout waiting for results");
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int exp);
    errors++;
    $display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, exp, results_seen);
  endtask

  // MHRRN order: true when slot a beats slot b
  function automatic bit hrrn_beats(int a, int b, logic [31:0] now);
    logic [31:0] wa, wb, ra, rb;
    logic [63:0] ka, kb;
    wa = now - t_arr[a];
    wb = now - t_arr[b];
    ra = (t_runs[a] != 0) ? t_runs[a] : 32'd1;
    rb = (t_runs[b] != 0) ? t_runs[b] : 32'd1;
    ka = 64'(t_prio[a]) + 64'(wa / ra);
    kb = 64'(t_prio[b]) + 64'(wb / rb);
    if (ka != kb) return ka > kb;
    return 64'(wa % ra) * 64'(rb) > 64'(wb % rb) * 64'(ra);
  endfunction

  function automatic int pick_next(logic [31:0] now);
    int best;
    best = -1;
    for (int i = 0; i < mlqs_pkg::TaskSlots; i++)
      if (t_run[i] && t_lvl[i] == mlqs_pkg::LvlRr && (best < 0 || t_arr[i] < t_arr[best]))
        best = i;
    if (best >= 0) return best;
    for (int i = 0; i < mlqs_pkg::TaskSlots; i++)
      if (t_run[i] && t_lvl[i] == mlqs_pkg::LvlLcfs && (best < 0 || t_arr[i] > t_arr[best]))
        best = i;
    if (best >= 0) return best;
    for (int i = 0; i < mlqs_pkg::TaskSlots; i++)
      if (t_run[i] && t_lvl[i] == mlqs_pkg::LvlMhrrn && (best < 0 || hrrn_beats(i, best, now)))
        best = i;
    return best;
  endfunction

  function automatic sched_res_t predict_sched(mlqs_pkg::opcode_e op, int s, bit fl,
                                               logic [1:0] ql, logic [7:0] pv,
                                               logic [31:0] now);
    sched_res_t r;
    int c;
    r = '0;
    case (op)
      mlqs_pkg::OP_SCHEDULE: begin
        c = pick_next(now);
        if (c >= 0) begin
          t_run[c] = 1'b0;
          if (t_runs[c] != 32'hFFFF_FFFF) t_runs[c]++;
          for (int i = 0; i < mlqs_pkg::TaskSlots; i++)
            if (t_run[i] && t_wait[i] != 16'hFFFF) t_wait[i]++;
          t_wait[c] = '0;
          for (int i = 0; i < mlqs_pkg::TaskSlots; i++)
            if (t_run[i] && t_wait[i] > aging_lim) begin
              if (t_lvl[i] > mlqs_pkg::LvlRr) t_lvl[i]--;
              t_wait[i] = '0;
            end
          r.chosen_valid = 1'b1;
          r.chosen_slot = 6'(c);
        end
      end
      mlqs_pkg::OP_NOP: ;
      mlqs_pkg::OP_ADMIT: begin
        t_occ[s] = 1'b1; t_run[s] = fl; t_lvl[s] = mlqs_pkg::LvlLcfs; t_arr[s] = now;
        t_runs[s] = 32'd1; t_wait[s] = '0; t_prio[s] = pv;
      end
      default: begin
        if (!t_occ[s]) r.status = 1'b1;
        else case (op)
          mlqs_pkg::OP_SET_RUN: t_run[s] = fl;
          mlqs_pkg::OP_END_RUN: begin
            t_run[s] = fl;
            if (fl && t_lvl[s] == mlqs_pkg::LvlRr) t_arr[s] = now;
          end
          mlqs_pkg::OP_SET_QUEUE: begin
            t_lvl[s] = (ql == 2'd0) ? mlqs_pkg::LvlRr : ql;
            t_wait[s] = '0;
          end
          mlqs_pkg::OP_SET_PRIO: t_prio[s] = pv;
          default: begin t_occ[s] = 1'b0; t_run[s] = 1'b0; end
        endcase
      end
    endcase
    return r;
  endfunction

  // Send one request and queue its expectation on acceptance
  task automatic send_req(mlqs_pkg::opcode_e op, int s, int fl, int ql, int pv,
                          logic [31:0] now);
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op; slot_i <= 6'(s); runnable_flag_i <= 1'(fl);
    queue_level_i <= 2'(ql); priority_value_i <= 8'(pv); now_i <= now;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_q.push_back(predict_sched(op, s, 1'(fl), 2'(ql), 8'(pv), now));
    if (op == mlqs_pkg::OP_SCHEDULE) scheds_hit++;
  endtask

  // Result checker
  initial begin
    sched_res_t e;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (expected_q.size() == 0) report_mismatch("unexpected result", 1, 0);
        else begin
          e = expected_q.pop_front();
          if (chosen_valid_o !== e.chosen_valid)
            report_mismatch("chosen_valid", chosen_valid_o, e.chosen_valid);
          if (chosen_slot_o !== e.chosen_slot)
            report_mismatch("chosen_slot", chosen_slot_o, e.chosen_slot);
          if (status_o !== e.status) report_mismatch("status", status_o, e.status);
        end
      end
    end
  end

  // Receiver stall: random bursts, or a long hold when requested
  initial begin
    int n;
    forever begin
      @(posedge clk_i);
      if (hold_rx) out_stall_i <= 1'b1;
      else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 12);
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else out_stall_i <= 1'b0;
    end
  end

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_aging_limit(logic [15:0] v);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    aging_lim = v;
  endtask

  function automatic logic [1:0] rand_lvl();
    return 2'($urandom_range(0, 3));
  endfunction

  // Directed: field extremes, every opcode and the special cases
  task automatic test_directed();
    send_req(mlqs_pkg::OP_SCHEDULE, 0, 0, 0, 0, 0);            // empty schedule
    send_req(mlqs_pkg::OP_SET_RUN, 63, 1, 0, 0, 5);            // unoccupied slot
    send_req(mlqs_pkg::OP_FREE, 7, 0, 0, 0, 5);
    send_req(mlqs_pkg::OP_NOP, 63, 1, 3, 255, 32'hFFFF_FFFF);
    send_req(mlqs_pkg::OP_ADMIT, 0, 1, 3, 255, 32'hFFFF_FFF0);
    send_req(mlqs_pkg::OP_ADMIT, 63, 1, 0, 0, 32'h0000_0010);
    send_req(mlqs_pkg::OP_ADMIT, 5, 0, 0, 17, 100);
    send_req(mlqs_pkg::OP_SCHEDULE, 0, 0, 0, 0, 200);          // LCFS latest arrival
    send_req(mlqs_pkg::OP_SET_QUEUE, 0, 0, 0, 0, 201);         // level 0 taken as RR
    send_req(mlqs_pkg::OP_END_RUN, 0, 1, 0, 0, 300);           // RR re-arrival
    send_req(mlqs_pkg::OP_SET_QUEUE, 5, 0, 3, 0, 301);
    send_req(mlqs_pkg::OP_SET_PRIO, 5, 0, 0, 255, 302);
    send_req(mlqs_pkg::OP_SET_RUN, 5, 1, 0, 0, 303);
    send_req(mlqs_pkg::OP_SCHEDULE, 0, 0, 0, 0, 400);
    send_req(mlqs_pkg::OP_SCHEDULE, 0, 0, 0, 0, 32'h0000_0005); // wrapped wait
    send_req(mlqs_pkg::OP_SET_QUEUE, 63, 0, 2, 0, 401);
    send_req(mlqs_pkg::OP_SCHEDULE, 0, 0, 0, 0, 402);
    send_req(mlqs_pkg::OP_SCHEDULE, 0, 0, 0, 0, 403);
    send_req(mlqs_pkg::OP_FREE, 5, 0, 0, 0, 404);
    send_req(mlqs_pkg::OP_END_RUN, 5, 1, 0, 0, 405);
    send_req(mlqs_pkg::OP_ADMIT, 0, 0, 0, 0, 406);              // overwrite occupied
  endtask

  // Random: every opcode in a weighted mix, with schedule the most frequent
  task automatic test_random(int n, int maxslot);
    int r, s;
    for (int i = 0; i < n; i++) begin
      tick += ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 40);
      r = $urandom_range(0, 99);
      s = $urandom_range(0, maxslot);
      if (r < 15)
        send_req(mlqs_pkg::OP_ADMIT, s, $urandom, rand_lvl(), $urandom, tick);
      else if (r < 30)
        send_req(mlqs_pkg::OP_SET_RUN, s, $urandom_range(0, 3) != 0, 0, 0, tick);
      else if (r < 40) send_req(mlqs_pkg::OP_END_RUN, s, $urandom, 0, 0, tick);
      else if (r < 50)
        send_req(mlqs_pkg::OP_SET_QUEUE, s, $urandom, rand_lvl(), 0, tick);
      else if (r < 56) send_req(mlqs_pkg::OP_SET_PRIO, s, $urandom, 0, $urandom, tick);
      else if (r < 60) send_req(mlqs_pkg::OP_FREE, s, 0, 0, 0, tick);
      else if (r < 62)
        send_req(mlqs_pkg::OP_NOP, s, $urandom, rand_lvl(), $urandom, $urandom);
      else send_req(mlqs_pkg::OP_SCHEDULE, s, $urandom, rand_lvl(), $urandom, tick);
    end
  endtask

  // Long receiver hold while requests keep coming
  task automatic test_backpressure();
    fork
      begin
        hold_rx = 1'b1;
        repeat (600) @(posedge clk_i);
        hold_rx = 1'b0;
      end
      test_random(20, 15);
    join
  endtask

  initial begin
    for (int i = 0; i < mlqs_pkg::TaskSlots; i++) begin
      t_occ[i] = 1'b0; t_run[i] = 1'b0; t_lvl[i] = '0; t_arr[i] = '0;
      t_runs[i] = '0; t_wait[i] = '0; t_prio[i] = '0;
    end
    aging_lim = 16'd10;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    write_aging_limit(16'd0);
    test_random(200, 15);
    write_aging_limit(16'hFFFF);
    test_random(150, 63);
    write_aging_limit(16'd3);
    test_backpressure();
    test_random(250, 7);
    write_aging_limit(16'd10);
    rx_idle_en = 1'b0;
    tx_idle_en = 1'b0;
    test_random(150, 31);
    drain();
    $display("Covered %0d results, %0d schedules, four aging limits, back-pressure hold.",
             results_seen, scheds_hit);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
